FILE: hdl/pf_pkg.sv
// ----------------------------------------------------------------------------
// pf_pkg
// Shared types, constants and square helpers for the Playfair digraph core.
// ----------------------------------------------------------------------------
package pf_pkg;

  localparam int LETTER_W = 5;
  localparam int SQ_N     = 5;
  localparam int POS_W    = 3;
  localparam int ROW_W    = SQ_N * LETTER_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = ROW_W;

  localparam logic [LETTER_W-1:0] LETTER_I     = 5'd8;
  localparam logic [LETTER_W-1:0] LETTER_J     = 5'd9;
  localparam logic [LETTER_W-1:0] FILLER_RESET = 5'd23;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DECRYPT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FILLER  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW0    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW1    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW2    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW3    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW4    = 3'd6;

  // Default square: a..z without j, row major
  localparam logic [ROW_W-1:0] ROW0_RESET = 25'd4294688;
  localparam logic [ROW_W-1:0] ROW1_RESET = 25'd10755269;
  localparam logic [ROW_W-1:0] ROW2_RESET = 25'd16201099;
  localparam logic [ROW_W-1:0] ROW3_RESET = 25'd21613104;
  localparam logic [ROW_W-1:0] ROW4_RESET = 25'd27025109;

  typedef logic [SQ_N-1:0][SQ_N-1:0][LETTER_W-1:0] square_t;

  typedef struct packed {
    logic [POS_W-1:0] r;
    logic [POS_W-1:0] c;
  } pos_t;

  // One digraph waiting for lookup
  typedef struct packed {
    logic                valid;
    logic [LETTER_W-1:0] l1;
    logic [LETTER_W-1:0] l2;
    logic                twice;
    logic                last;
  } job_t;

  // One looked-up digraph
  typedef struct packed {
    logic                valid;
    logic [LETTER_W-1:0] o1;
    logic [LETTER_W-1:0] o2;
    logic                twice;
    logic                last;
  } res_t;

  // First occurrence in row-major order; absent letters land on row 0, column 0
  function automatic pos_t locate(square_t sq, logic [LETTER_W-1:0] letter);
    pos_t p;
    p = '0;
    for (int r = SQ_N - 1; r >= 0; r--) begin
      for (int c = SQ_N - 1; c >= 0; c--) begin
        if (sq[r][c] == letter) begin
          p.r = POS_W'(r);
          p.c = POS_W'(c);
        end
      end
    end
    return p;
  endfunction

  function automatic logic [POS_W-1:0] step_pos(logic [POS_W-1:0] v, logic dec);
    logic [POS_W-1:0] s;
    if (dec) begin
      s = (v == '0) ? POS_W'(SQ_N - 1) : v - 1'b1;
    end else begin
      s = (v == POS_W'(SQ_N - 1)) ? '0 : v + 1'b1;
    end
    return s;
  endfunction

endpackage

FILE: hdl/pf_stream_if.sv
// ----------------------------------------------------------------------------
// pf_stream_if
// Valid/ready channels for incoming characters and outgoing cipher letters.
// ----------------------------------------------------------------------------
interface pf_text_if
  import pf_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [LETTER_W-1:0] letter_code;
  logic                is_gap;
  logic                text_end;

  modport source (output valid, output letter_code, output is_gap, output text_end,
                  input ready);
  modport sink   (input valid, input letter_code, input is_gap, input text_end,
                  output ready);
endinterface

interface pf_cipher_if
  import pf_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [LETTER_W-1:0] out_letter;
  logic                out_last;

  modport source (output valid, output out_letter, output out_last, input ready);
  modport sink   (input valid, input out_letter, input out_last, output ready);
endinterface

FILE: hdl/pf_pair.sv
// ----------------------------------------------------------------------------
// pf_pair
// Gap skipping, j folding and digraph pairing into the job register.
// ----------------------------------------------------------------------------
module pf_pair
  import pf_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  pf_text_if.sink             text,
  input  logic [LETTER_W-1:0] filler,
  input  logic                take,
  output job_t                job,
  output logic                held_valid
);

  logic [LETTER_W-1:0] held_letter;
  logic [LETTER_W-1:0] held_letter_next;
  logic                held_valid_next;
  logic [LETTER_W-1:0] letter;
  logic                fire;
  job_t                job_new;

  assign text.ready = !job.valid || take;
  assign fire       = text.valid && text.ready;
  assign letter     = (text.letter_code == LETTER_J) ? LETTER_I : text.letter_code;

  always_comb begin
    job_new          = '0;
    held_letter_next = held_letter;
    held_valid_next  = held_valid;
    priority if (text.is_gap) begin
      if (text.text_end && held_valid) begin
        job_new = '{valid: 1'b1, l1: held_letter, l2: filler, twice: 1'b0, last: 1'b1};
      end
    end else if (!held_valid) begin
      if (text.text_end) begin
        job_new = '{valid: 1'b1, l1: letter, l2: filler, twice: 1'b0, last: 1'b1};
      end else begin
        held_letter_next = letter;
        held_valid_next  = 1'b1;
      end
    end else if (letter == held_letter) begin
      // doubled letter: pad it, keep it held; at the end the pair repeats
      job_new = '{valid: 1'b1, l1: held_letter, l2: filler,
                  twice: text.text_end, last: text.text_end};
    end else begin
      job_new = '{valid: 1'b1, l1: held_letter, l2: letter,
                  twice: 1'b0, last: text.text_end};
      held_valid_next = 1'b0;
    end
    if (text.text_end) begin
      held_letter_next = '0;
      held_valid_next  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_letter <= '0;
      held_valid  <= 1'b0;
      job.valid   <= 1'b0;
    end else if (fire) begin
      held_letter <= held_letter_next;
      held_valid  <= held_valid_next;
      job.valid   <= job_new.valid;
    end else if (take) begin
      job.valid   <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      job.l1    <= job_new.l1;
      job.l2    <= job_new.l2;
      job.twice <= job_new.twice;
      job.last  <= job_new.last;
    end
  end

endmodule

FILE: hdl/pf_lookup.sv
// ----------------------------------------------------------------------------
// pf_lookup
// Locates both letters in the square and applies the Playfair rules.
// ----------------------------------------------------------------------------
module pf_lookup
  import pf_pkg::*;
(
  input  square_t sq,
  input  logic    decrypt,
  input  job_t    job,
  output res_t    res
);

  pos_t p1;
  pos_t p2;

  assign p1 = locate(sq, job.l1);
  assign p2 = locate(sq, job.l2);

  always_comb begin
    res.valid = job.valid;
    res.twice = job.twice;
    res.last  = job.last;
    priority if (p1.r == p2.r) begin
      res.o1 = sq[p1.r][step_pos(p1.c, decrypt)];
      res.o2 = sq[p2.r][step_pos(p2.c, decrypt)];
    end else if (p1.c == p2.c) begin
      res.o1 = sq[step_pos(p1.r, decrypt)][p1.c];
      res.o2 = sq[step_pos(p2.r, decrypt)][p2.c];
    end else begin
      // rectangle: swap columns
      res.o1 = sq[p1.r][p2.c];
      res.o2 = sq[p2.r][p1.c];
    end
  end

endmodule

FILE: hdl/pf_emit.sv
// ----------------------------------------------------------------------------
// pf_emit
// Result register and letter serializer: one output letter per beat.
// ----------------------------------------------------------------------------
module pf_emit
  import pf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  res_t       d,
  output logic       take,
  pf_cipher_if.source cipher
);

  res_t       res;
  logic [1:0] beat;
  logic [1:0] final_beat;
  logic       fire;
  logic       done;
  logic       load;

  assign final_beat = res.twice ? 2'd3 : 2'd1;
  assign fire       = cipher.valid && cipher.ready;
  assign done       = fire && (beat == final_beat);
  assign take       = !res.valid || done;
  assign load       = d.valid && take;

  assign cipher.valid      = res.valid;
  assign cipher.out_letter = beat[0] ? res.o2 : res.o1;
  assign cipher.out_last   = res.last && (beat == final_beat);

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
      beat      <= '0;
    end else if (load) begin
      res.valid <= 1'b1;
      beat      <= '0;
    end else if (done) begin
      res.valid <= 1'b0;
      beat      <= '0;
    end else if (fire) begin
      beat      <= beat + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res.o1    <= d.o1;
      res.o2    <= d.o2;
      res.twice <= d.twice;
      res.last  <= d.last;
    end
  end

endmodule

FILE: hdl/playfair_digraph_cipher_core.sv
// ----------------------------------------------------------------------------
// playfair_digraph_cipher_core
// Streaming Playfair 5x5 cipher with a software-loaded key square.
// ----------------------------------------------------------------------------
// The item that completes a digraph passes the job register and then the
// result register, from which the first letter is offered; the second letter
// follows on the next output beat.
// Throughput: one letter per cycle on the output while it is not stalled, so
// the output serializer sets the rate of paired items. Held first letters make no job.
// Reset (synchronous): clears the held letter and pipeline, restores the
// default square (a..z without j), encrypt mode and filler x.
module playfair_digraph_cipher_core
  import pf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  pf_text_if.sink               text,
  pf_cipher_if.source           cipher,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic                decrypt;
  logic [LETTER_W-1:0] filler;
  square_t             sq;
  job_t                job;
  res_t                res_d;
  logic                take;
  logic                held_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      decrypt <= 1'b0;
      filler  <= FILLER_RESET;
      sq[0]   <= ROW0_RESET;
      sq[1]   <= ROW1_RESET;
      sq[2]   <= ROW2_RESET;
      sq[3]   <= ROW3_RESET;
      sq[4]   <= ROW4_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DECRYPT: decrypt <= cfg_data[0];
        CFG_FILLER:  filler  <= cfg_data[LETTER_W-1:0];
        CFG_ROW0:    sq[0]   <= cfg_data[ROW_W-1:0];
        CFG_ROW1:    sq[1]   <= cfg_data[ROW_W-1:0];
        CFG_ROW2:    sq[2]   <= cfg_data[ROW_W-1:0];
        CFG_ROW3:    sq[3]   <= cfg_data[ROW_W-1:0];
        CFG_ROW4:    sq[4]   <= cfg_data[ROW_W-1:0];
        default: ;
      endcase
    end
  end

  pf_pair u_pair (
    .clk        (clk),
    .rst        (rst),
    .text       (text),
    .filler     (filler),
    .take       (take),
    .job        (job),
    .held_valid (held_valid)
  );

  pf_lookup u_lookup (
    .sq      (sq),
    .decrypt (decrypt),
    .job     (job),
    .res     (res_d)
  );

  pf_emit u_emit (
    .clk    (clk),
    .rst    (rst),
    .d      (res_d),
    .take   (take),
    .cipher (cipher)
  );

  // a stalled job holds its contents
  a_job_hold: assert property (@(posedge clk) disable iff (rst)
    job.valid && !take |=> job.valid && $stable(job))
    else $error("job register changed while stalled");

  // nothing stays held once a message ends
  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    text.valid && text.ready && text.text_end |=> !held_valid)
    else $error("held letter survived end of message");

  // a result is only offered while a digraph was loaded before
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    !cipher.valid && !job.valid |=> !cipher.valid)
    else $error("result appeared with no job");

endmodule

FILE: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the streaming Playfair core. Characters go in over
// the text channel and cipher letters are checked in order against an
// in-bench digraph predictor. Covers the reset square, shuffled, random,
// all-zero and all-ones squares, both shift directions, and random stalls on
// both channels.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pf_pkg::*;

  localparam int WATCHDOG_CYCLES  = 2000;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES     = 8;
  localparam int DIRECTED_N       = 25;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;  // decodes to no register
  localparam logic [ROW_W-1:0]     ROW_ONES  = '1;

  typedef struct packed {
    logic [LETTER_W-1:0] letter;
    logic                last;
  } cipher_item_t;

  typedef struct packed {
    logic [LETTER_W-1:0] letter;
    logic                gap;
    logic                fin;
    logic                typed;
    logic [LETTER_W-1:0] exp1;
    logic [LETTER_W-1:0] exp2;
    logic                exp_last;
  } text_row_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  pf_text_if   text_ch();
  pf_cipher_if cipher_ch();

  playfair_digraph_cipher_core u_top (
    .clk       (clk),
    .rst       (rst),
    .text      (text_ch),
    .cipher    (cipher_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Predictor copy of the key square, mode and pairing state
  logic                decrypt_on;
  logic [LETTER_W-1:0] pad_code;
  logic [ROW_W-1:0]    key_row [SQ_N];
  logic [LETTER_W-1:0] pending_letter;
  logic                pending_valid;
  cipher_item_t        cipher_expect_q[$];

  logic [LETTER_W-1:0] last_code = '0;
  int  errors          = 0;
  int  items_sent      = 0;
  int  letters_checked = 0;
  bit  idle_on         = 1'b1;
  bit  hold_long       = 1'b0;

  // Reset square: a..z without j
  //   a b c d e / f g h i k / l m n o p / q r s t u / v w x y z
  text_row_t directed_tab [DIRECTED_N] = '{
    '{5'd0,  1'b0, 1'b0, 1'b0, 5'd0,  5'd0,  1'b0},  // hold a
    '{5'd1,  1'b0, 1'b0, 1'b1, 5'd1,  5'd2,  1'b0},  // ab, same row -> bc
    '{5'd0,  1'b0, 1'b0, 1'b0, 5'd0,  5'd0,  1'b0},
    '{5'd5,  1'b0, 1'b0, 1'b1, 5'd5,  5'd11, 1'b0},  // af, same column -> fl
    '{5'd0,  1'b0, 1'b0, 1'b0, 5'd0,  5'd0,  1'b0},
    '{5'd25, 1'b0, 1'b1, 1'b1, 5'd4,  5'd21, 1'b1},  // az, rectangle -> ev
    '{5'd25, 1'b0, 1'b1, 1'b1, 5'd21, 5'd24, 1'b1},  // lone z padded -> vy
    '{5'd31, 1'b1, 1'b0, 1'b0, 5'd0,  5'd0,  1'b0},  // gap, nothing held
    '{5'd9,  1'b0, 1'b0, 1'b0, 5'd0,  5'd0,  1'b0},  // j folds onto i
    '{5'd8,  1'b0, 1'b0, 1'b1, 5'd7,  5'd24, 1'b0},  // double i split -> hy
    '{5'd31, 1'b1, 1'b0, 1'b0, 5'd0,  5'd0,  1'b0},  // gap keeps held i
    '{5'd0,  1'b1, 1'b1, 1'b1, 5'd7,  5'd24, 1'b1},  // gap ending pads held i
    '{5'd17, 1'b1, 1'b1, 1'b0, 5'd0,  5'd0,  1'b0},  // gap ending, nothing held
    '{5'd23, 1'b0, 1'b0, 1'b0, 5'd0,  5'd0,  1'b0},
    '{5'd23, 1'b0, 1'b1, 1'b0, 5'd0,  5'd0,  1'b0},  // filler doubled at end
    '{5'd31, 1'b0, 1'b0, 1'b0, 5'd0,  5'd0,  1'b0},  // codes off the square
    '{5'd26, 1'b0, 1'b0, 1'b0, 5'd0,  5'd0,  1'b0},
    '{5'd30, 1'b0, 1'b1, 1'b0, 5'd0,  5'd0,  1'b0},
    '{5'd10, 1'b0, 1'b0, 1'b0, 5'd0,  5'd0,  1'b0},
    '{5'd10, 1'b0, 1'b1, 1'b0, 5'd0,  5'd0,  1'b0},  // double at end
    '{5'd24, 1'b0, 1'b0, 1'b0, 5'd0,  5'd0,  1'b0},
    '{5'd9,  1'b0, 1'b1, 1'b0, 5'd0,  5'd0,  1'b0},
    '{5'd25, 1'b0, 1'b0, 1'b0, 5'd0,  5'd0,  1'b0},
    '{5'd22, 1'b0, 1'b0, 1'b1, 5'd21, 5'd23, 1'b0},  // zw, same row -> vx
    '{5'd19, 1'b0, 1'b1, 1'b0, 5'd0,  5'd0,  1'b0}
  };

  function automatic logic [LETTER_W-1:0] key_at(int r, int c);
    return key_row[r][c*LETTER_W +: LETTER_W];
  endfunction

  // Append one letter to the expected stream
  function automatic void expect_letter(input cipher_item_t want_item);
    cipher_expect_q = {cipher_expect_q, want_item};
  endfunction

  // First hit in row-major order; misses land on row 0, column 0
  function automatic void find_letter(input logic [LETTER_W-1:0] code,
                                      output int r, output int c);
    bit found;
    found = 1'b0;
    r = 0;
    c = 0;
    for (int i = 0; i < SQ_N; i++) begin
      for (int k = 0; k < SQ_N; k++) begin
        if (!found && key_at(i, k) == code) begin
          r = i;
          c = k;
          found = 1'b1;
        end
      end
    end
  endfunction

  function automatic int step_idx(int v);
    return decrypt_on ? (v + SQ_N - 1) % SQ_N : (v + 1) % SQ_N;
  endfunction

  function automatic void encode_pair(input logic [LETTER_W-1:0] l1, l2, input logic last,
                                      inout cipher_item_t [3:0] res, inout int n);
    int r1, c1, r2, c2;
    find_letter(l1, r1, c1);
    find_letter(l2, r2, c2);
    if (r1 == r2) begin
      res[n]   = '{key_at(r1, step_idx(c1)), 1'b0};
      res[n+1] = '{key_at(r2, step_idx(c2)), last};
    end else if (c1 == c2) begin
      res[n]   = '{key_at(step_idx(r1), c1), 1'b0};
      res[n+1] = '{key_at(step_idx(r2), c2), last};
    end else begin
      res[n]   = '{key_at(r1, c2), 1'b0};
      res[n+1] = '{key_at(r2, c1), last};
    end
    n += 2;
  endfunction

  function automatic int predict_cipher(input logic [LETTER_W-1:0] code, input logic gap, fin,
                                        output cipher_item_t [3:0] res);
    logic [LETTER_W-1:0] letter;
    int n;
    n = 0;
    res = '0;
    letter = (code == LETTER_J) ? LETTER_I : code;
    if (gap) begin
      if (fin && pending_valid) encode_pair(pending_letter, pad_code, 1'b1, res, n);
    end else if (!pending_valid) begin
      if (fin) begin
        encode_pair(letter, pad_code, 1'b1, res, n);
      end else begin
        pending_letter = letter;
        pending_valid  = 1'b1;
      end
    end else if (letter == pending_letter) begin
      // split the double; the letter stays held as the next first letter
      encode_pair(pending_letter, pad_code, 1'b0, res, n);
      if (fin) encode_pair(letter, pad_code, 1'b1, res, n);
    end else begin
      encode_pair(pending_letter, letter, fin, res, n);
      pending_valid = 1'b0;
    end
    if (fin) begin
      pending_valid  = 1'b0;
      pending_letter = '0;
    end
    return n;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance
  task automatic send_text(input logic [LETTER_W-1:0] code, input logic gap, fin,
                           input bit typed, input cipher_item_t [1:0] typed_res);
    cipher_item_t [3:0] res;
    int n;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      text_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    text_ch.valid       <= 1'b1;
    text_ch.letter_code <= code;
    text_ch.is_gap      <= gap;
    text_ch.text_end    <= fin;
    do @(posedge clk); while (text_ch.ready !== 1'b1);
    n = predict_cipher(code, gap, fin, res);
    if (typed) begin
      expect_letter(typed_res[0]);
      expect_letter(typed_res[1]);
    end else begin
      for (int i = 0; i < n; i++) expect_letter(res[i]);
    end
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_random(input bit last_one);
    logic [LETTER_W-1:0] code;
    logic gap, fin;
    int pick;
    pick = $urandom_range(0, 99);
    gap  = ($urandom_range(0, 99) < 8);
    fin  = last_one || ($urandom_range(0, 99) < 7);
    if (gap) begin
      code = LETTER_W'($urandom);
    end else begin
      // mostly letters on the square, with doubles, j and off-square codes mixed in
      if (pick < 55)      code = key_at($urandom_range(0, SQ_N - 1), $urandom_range(0, SQ_N - 1));
      else if (pick < 78) code = LETTER_W'($urandom_range(0, 25));
      else if (pick < 88) code = last_code;
      else if (pick < 93) code = LETTER_J;
      else                code = LETTER_W'($urandom_range(26, 31));
      last_code = code;
    end
    send_text(code, gap, fin, 1'b0, '0);
  endtask

  task automatic wait_drained();
    while (cipher_expect_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Each run ends its last message, so nothing is held across a key change
  task automatic run_text(input int count);
    for (int i = 0; i < count; i++) send_random(i == count - 1);
    text_ch.valid <= 1'b0;
    wait_drained();
  endtask

  // Leaves cfg_we high; the caller lowers it after the last write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    case (idx)
      CFG_DECRYPT: decrypt_on = data[0];
      CFG_FILLER:  pad_code = data[LETTER_W-1:0];
      CFG_ROW0, CFG_ROW1, CFG_ROW2, CFG_ROW3, CFG_ROW4: key_row[idx - CFG_ROW0] = data;
      default: ;
    endcase
  endtask

  task automatic load_config(input logic dec, input logic [LETTER_W-1:0] pad,
                             input logic [SQ_N-1:0][ROW_W-1:0] sq);
    // junk in the upper bits must be masked off
    write_reg(CFG_DECRYPT, (CFG_DATA_W'($urandom) << 1) | CFG_DATA_W'(dec));
    write_reg(CFG_FILLER, (CFG_DATA_W'($urandom) << LETTER_W) | CFG_DATA_W'(pad));
    write_reg(CFG_ROW0, sq[0]);
    write_reg(CFG_ROW1, sq[1]);
    write_reg(CFG_ROW2, sq[2]);
    write_reg(CFG_ROW3, sq[3]);
    write_reg(CFG_ROW4, sq[4]);
    write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
    cfg_we <= 1'b0;
  endtask

  function automatic logic [SQ_N-1:0][ROW_W-1:0] shuffled_square();
    logic [LETTER_W-1:0] pool [25];
    logic [LETTER_W-1:0] t;
    logic [SQ_N-1:0][ROW_W-1:0] sq;
    int k, j;
    k = 0;
    for (int c = 0; c < 26; c++) begin
      if (LETTER_W'(c) != LETTER_J) begin
        pool[k] = LETTER_W'(c);
        k++;
      end
    end
    for (int i = 24; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = pool[i];
      pool[i] = pool[j];
      pool[j] = t;
    end
    for (int i = 0; i < 25; i++) sq[i / SQ_N][(i % SQ_N)*LETTER_W +: LETTER_W] = pool[i];
    return sq;
  endfunction

  initial begin : clock_gen
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin : cipher_sink
    int stall_n;
    bit hold_taken;
    stall_n = 0;
    hold_taken = 1'b0;
    cipher_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_long && !hold_taken) begin
        // long back-pressure: let the core fill up and stall its input
        hold_taken = 1'b1;
        stall_n = LONG_HOLD_CYCLES;
      end else if (stall_n == 0 && idle_on && $urandom_range(0, 9) == 0) begin
        stall_n = $urandom_range(1, 12);
      end
      if (stall_n > 0) begin
        cipher_ch.ready <= 1'b0;
        stall_n--;
      end else begin
        cipher_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : letter_check
    cipher_item_t want;
    if (!rst && cipher_ch.valid === 1'b1 && cipher_ch.ready === 1'b1) begin
      if (cipher_expect_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected cipher letter %0d last %0b", $time,
                 cipher_ch.out_letter, cipher_ch.out_last);
      end else begin
        want = cipher_expect_q.pop_front();
        letters_checked++;
        if (cipher_ch.out_letter !== want.letter) begin
          errors++;
          $display("%0t: out_letter expected %0d actual %0d", $time,
                   want.letter, cipher_ch.out_letter);
        end
        if (cipher_ch.out_last !== want.last) begin
          errors++;
          $display("%0t: out_last expected %0b actual %0b", $time,
                   want.last, cipher_ch.out_last);
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_CYCLES) begin
      @(posedge clk);
      if ((text_ch.valid === 1'b1 && text_ch.ready === 1'b1) ||
          (cipher_ch.valid === 1'b1 && cipher_ch.ready === 1'b1)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no item moved for %0d cycles, %0d letters still expected", $time,
             quiet, cipher_expect_q.size());
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    logic [SQ_N-1:0][ROW_W-1:0] sq;
    cipher_item_t [1:0] pair;
    rst                 = 1'b1;
    cfg_we              = 1'b0;
    cfg_index           = '0;
    cfg_data            = '0;
    text_ch.valid       = 1'b0;
    text_ch.letter_code = '0;
    text_ch.is_gap      = 1'b0;
    text_ch.text_end    = 1'b0;
    decrypt_on          = 1'b0;
    pad_code            = FILLER_RESET;
    key_row[0]          = ROW0_RESET;
    key_row[1]          = ROW1_RESET;
    key_row[2]          = ROW2_RESET;
    key_row[3]          = ROW3_RESET;
    key_row[4]          = ROW4_RESET;
    pending_letter      = '0;
    pending_valid       = 1'b0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: known digraphs first
    foreach (directed_tab[i]) begin
      pair[0] = '{directed_tab[i].exp1, 1'b0};
      pair[1] = '{directed_tab[i].exp2, directed_tab[i].exp_last};
      send_text(directed_tab[i].letter, directed_tab[i].gap, directed_tab[i].fin,
                directed_tab[i].typed, pair);
    end
    text_ch.valid <= 1'b0;
    wait_drained();
    run_text(40);

    // decrypt over a shuffled square, with one long output stall
    load_config(1'b1, LETTER_W'($urandom_range(0, 25)), shuffled_square());
    hold_long = 1'b1;
    run_text(60);

    // extremes: all-zero and all-ones squares, lowest and highest filler
    load_config(1'b0, 5'd0, '0);
    run_text(20);
    load_config(1'b1, 5'd25, {SQ_N{ROW_ONES}});
    run_text(20);

    // arbitrary codes: repeats and off-alphabet entries in the square
    for (int i = 0; i < SQ_N; i++) sq[i] = ROW_W'($urandom);
    load_config(1'($urandom), LETTER_W'($urandom_range(0, 25)), sq);
    run_text(60);

    // closing stretch at full rate
    idle_on = 1'b0;
    load_config(1'b0, LETTER_W'($urandom_range(0, 25)), shuffled_square());
    run_text(45);

    $display("Sent %0d text items and checked %0d cipher letters in both shift directions,",
             items_sent, letters_checked);
    $display("over reset, shuffled, random, all-zero and all-ones key squares.");
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/pf_pkg.sv
hdl/pf_stream_if.sv
hdl/pf_pair.sv
hdl/pf_lookup.sv
hdl/pf_emit.sv
hdl/playfair_digraph_cipher_core.sv
bench/tb.sv
